[sv/docbq_pkg.sv]
// Shared constants, types and pointer helpers for the chunked byte queue.
// No dependencies; imported by the top level.
`default_nettype none

package docbq_pkg;

    // Storage sizes
    localparam int CAPACITY   = 4096;
    localparam int MAX_CHUNKS = 4096;

    // Fixed field widths
    localparam int BYTE_W      = 8;
    localparam int LEN_FIELD_W = 13;
    localparam int MAXB_W      = 13;
    localparam int OCC_W       = 13;
    localparam int DROP_W      = 32;

    // Derived widths
    localparam int BA_W  = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CA_W  = $clog2(MAX_CHUNKS);
    localparam int CC_W  = $clog2(MAX_CHUNKS + 1);
    localparam int CMP_W = ((CNT_W > LEN_FIELD_W) ? CNT_W :
                           ((MAXB_W > LEN_FIELD_W) ? MAXB_W : LEN_FIELD_W)) + 1;

    localparam logic [MAXB_W-1:0] MAX_BYTES_RESET = MAXB_W'(4096);

    // Operation codes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_PULL = 1'b1;

    typedef logic [BA_W-1:0]  byte_ptr_t;
    typedef logic [CNT_W-1:0] byte_cnt_t;
    typedef logic [CA_W-1:0]  chunk_ptr_t;
    typedef logic [CC_W-1:0]  chunk_cnt_t;
    typedef logic [CMP_W-1:0] cmp_t;

    // Advance a byte pointer by n (n never exceeds the capacity)
    function automatic byte_ptr_t byte_wrap_add(byte_ptr_t ptr, byte_cnt_t n);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(ptr) + (CNT_W+1)'(n);
        if (sum >= (CNT_W+1)'(CAPACITY))
            sum = sum - (CNT_W+1)'(CAPACITY);
        return BA_W'(sum);
    endfunction

    // Step a chunk pointer forward by one
    function automatic chunk_ptr_t chunk_inc(chunk_ptr_t ptr);
        chunk_ptr_t res;
        if (ptr == CA_W'(MAX_CHUNKS - 1))
            res = '0;
        else
            res = ptr + CA_W'(1);
        return res;
    endfunction

    // Step a chunk pointer back by one
    function automatic chunk_ptr_t chunk_dec(chunk_ptr_t ptr);
        chunk_ptr_t res;
        if (ptr == '0)
            res = CA_W'(MAX_CHUNKS - 1);
        else
            res = ptr - CA_W'(1);
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/drop_oldest_chunk_byte_queue_unit.sv]
// Top level of the chunked byte queue that drops oldest chunks to make room.
// Depends on docbq_pkg and docbq_ram (byte store and chunk length table).
//
// Usage:
//   Command channel: drive mode, data_byte, chunk_start and chunk_length and
//   raise start; the command is taken at a clock edge where start is high and
//   busy is low. Exactly one result follows per command: done is high for one
//   cycle with out_byte, out_valid, occupancy, full_flag, dropped_total and
//   overflow_flag. The receiver cannot stall; results must be taken then.
//   Config channel: cfg_data is written into max_bytes when cfg_valid and
//   cfg_ready are high (cfg_ready is always high); write only while idle.
//   Sequence: a push without chunk start goes IDLE, PUSH. A push with chunk
//     start goes DROP, which drops one oldest chunk per step (with a LOAD
//     after each drop whose next head length comes from the length table)
//     and then closes the tail chunk, then PUSH. A pull goes PULL, skipping
//     empty head chunks (each with a LOAD when the next head is in the table),
//     plus a LOAD when the drained head hands over to a chunk in the table.
//   The length table has one read port; each head change that lands on a
//   stored chunk waits in LOAD for its read. done rises in the cycle where
//   busy falls, so the next command may be taken at that same edge.
//   Reset: pointers, counts and dropped_total clear, max_bytes goes to 4096;
//   the memories are not cleared and no clearing pass is needed.
`default_nettype none

module drop_oldest_chunk_byte_queue_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // command channel
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              mode,
    input  wire logic [docbq_pkg::BYTE_W-1:0]      data_byte,
    input  wire logic                              chunk_start,
    input  wire logic [docbq_pkg::LEN_FIELD_W-1:0] chunk_length,
    // result channel
    output logic                                   done,
    output logic      [docbq_pkg::BYTE_W-1:0]      out_byte,
    output logic                                   out_valid,
    output logic      [docbq_pkg::OCC_W-1:0]       occupancy,
    output logic                                   full_flag,
    output logic      [docbq_pkg::DROP_W-1:0]      dropped_total,
    output logic                                   overflow_flag,
    // configuration channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [docbq_pkg::MAXB_W-1:0]      cfg_data
);

    import docbq_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DROP = 5'b00010,
        ST_PUSH = 5'b00100,
        ST_PULL = 5'b01000,
        ST_LOAD = 5'b10000
    } state_t;

    // Control state
    state_t               state_reg, state_next;
    state_t               resume_reg, resume_next;
    byte_ptr_t            byte_head_reg, byte_head_next;
    byte_ptr_t            byte_tail_reg, byte_tail_next;
    chunk_ptr_t           chunk_head_reg, chunk_head_next;
    chunk_ptr_t           chunk_tail_reg, chunk_tail_next;
    chunk_cnt_t           chunk_count_reg, chunk_count_next;
    byte_cnt_t            bytes_held_reg, bytes_held_next;
    logic [DROP_W-1:0]    dropped_reg, dropped_next;
    logic [MAXB_W-1:0]    max_bytes_reg, max_bytes_next;
    logic                 done_reg, done_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 oflow_reg, oflow_next;

    // Payload state: head/tail chunk lengths kept out of the table, command fields
    byte_cnt_t            head_len_reg, head_len_next;
    byte_cnt_t            tail_len_reg, tail_len_next;
    logic [BYTE_W-1:0]    data_reg, data_next;
    logic                 cstart_reg, cstart_next;
    logic [LEN_FIELD_W-1:0] clen_reg, clen_next;

    // Memory ports
    logic                 byte_wr_en, byte_rd_en;
    logic [BYTE_W-1:0]    byte_rd_data;
    logic                 len_wr_en, len_rd_en;
    byte_cnt_t            len_rd_data;

    // Helpers
    byte_cnt_t            cur_head_len;
    byte_cnt_t            pop_len;
    byte_cnt_t            tail_len_base;
    chunk_ptr_t           head_inc;
    chunk_ptr_t           tail_last;
    logic                 drop_needed;
    logic                 push_open;
    logic                 accept;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // Head length: the tail register when only one chunk is held
    assign cur_head_len  = (chunk_count_reg == CC_W'(1)) ? tail_len_reg : head_len_reg;
    assign pop_len       = cur_head_len - CNT_W'(1);
    assign head_inc      = chunk_inc(chunk_head_reg);
    assign tail_last     = chunk_dec(chunk_tail_reg);
    assign push_open     = !cstart_reg && (chunk_count_reg == '0);
    assign tail_len_base = push_open ? '0 : tail_len_reg;
    assign drop_needed   = (chunk_count_reg != '0) &&
                           (((CMP_W'(bytes_held_reg) + CMP_W'(clen_reg)) >
                             CMP_W'(max_bytes_reg)) ||
                            (chunk_count_reg >= CC_W'(MAX_CHUNKS)));

    // Byte store
    docbq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY)
    ) u_byte_ram (
        .clk     (clk),
        .wr_en   (byte_wr_en),
        .wr_addr (byte_tail_reg),
        .wr_data (data_reg),
        .rd_en   (byte_rd_en),
        .rd_addr (byte_head_reg),
        .rd_data (byte_rd_data)
    );

    // Chunk length table: lengths of closed chunks behind the head
    docbq_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_CHUNKS)
    ) u_len_ram (
        .clk     (clk),
        .wr_en   (len_wr_en),
        .wr_addr (tail_last),
        .wr_data (tail_len_reg),
        .rd_en   (len_rd_en),
        .rd_addr (head_inc),
        .rd_data (len_rd_data)
    );

    // Sequencer: dispatch, drop oldest chunks, push, pull, wait on table read
    always_comb
    begin
        state_next       = state_reg;
        resume_next      = resume_reg;
        byte_head_next   = byte_head_reg;
        byte_tail_next   = byte_tail_reg;
        chunk_head_next  = chunk_head_reg;
        chunk_tail_next  = chunk_tail_reg;
        chunk_count_next = chunk_count_reg;
        bytes_held_next  = bytes_held_reg;
        dropped_next     = dropped_reg;
        max_bytes_next   = max_bytes_reg;
        out_valid_next   = out_valid_reg;
        oflow_next       = oflow_reg;
        head_len_next    = head_len_reg;
        tail_len_next    = tail_len_reg;
        data_next        = data_reg;
        cstart_next      = cstart_reg;
        clen_next        = clen_reg;
        byte_wr_en       = 1'b0;
        byte_rd_en       = 1'b0;
        len_wr_en        = 1'b0;
        len_rd_en        = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            max_bytes_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    data_next      = data_byte;
                    cstart_next    = chunk_start;
                    clen_next      = chunk_length;
                    out_valid_next = 1'b0;
                    oflow_next     = 1'b0;
                    if (mode == MODE_PULL)
                        state_next = ST_PULL;
                    else if (chunk_start)
                        state_next = ST_DROP;
                    else
                        state_next = ST_PUSH;
                end
            end

            ST_DROP:
            begin
                if (drop_needed)
                begin
                    // Drop the whole head chunk and count its bytes
                    dropped_next     = dropped_reg + DROP_W'(cur_head_len);
                    bytes_held_next  = bytes_held_reg - cur_head_len;
                    byte_head_next   = byte_wrap_add(byte_head_reg, cur_head_len);
                    chunk_head_next  = head_inc;
                    chunk_count_next = chunk_count_reg - CC_W'(1);
                    if (chunk_count_reg > CC_W'(2))
                    begin
                        len_rd_en   = 1'b1;
                        resume_next = ST_DROP;
                        state_next  = ST_LOAD;
                    end
                end
                else
                begin
                    // Close the current tail chunk and open a new one
                    if (chunk_count_reg != '0)
                    begin
                        len_wr_en = 1'b1;
                    end
                    if (chunk_count_reg == CC_W'(1))
                    begin
                        head_len_next = tail_len_reg;
                    end
                    tail_len_next    = '0;
                    chunk_tail_next  = chunk_inc(chunk_tail_reg);
                    chunk_count_next = chunk_count_reg + CC_W'(1);
                    state_next       = ST_PUSH;
                end
            end

            ST_PUSH:
            begin
                if (push_open)
                begin
                    chunk_tail_next  = chunk_inc(chunk_tail_reg);
                    chunk_count_next = CC_W'(1);
                end
                tail_len_next = tail_len_base;
                if (bytes_held_reg >= CNT_W'(CAPACITY))
                begin
                    oflow_next = 1'b1;
                end
                else
                begin
                    byte_wr_en      = 1'b1;
                    byte_tail_next  = byte_wrap_add(byte_tail_reg, CNT_W'(1));
                    bytes_held_next = bytes_held_reg + CNT_W'(1);
                    tail_len_next   = tail_len_base + CNT_W'(1);
                end
                state_next = ST_IDLE;
            end

            ST_PULL:
            begin
                if (bytes_held_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if ((chunk_count_reg > CC_W'(1)) && (cur_head_len == '0))
                begin
                    // Skip an empty head chunk
                    chunk_head_next  = head_inc;
                    chunk_count_next = chunk_count_reg - CC_W'(1);
                    if (chunk_count_reg > CC_W'(2))
                    begin
                        len_rd_en   = 1'b1;
                        resume_next = ST_PULL;
                        state_next  = ST_LOAD;
                    end
                end
                else
                begin
                    // Pop one byte from the head chunk
                    byte_rd_en      = 1'b1;
                    out_valid_next  = 1'b1;
                    byte_head_next  = byte_wrap_add(byte_head_reg, CNT_W'(1));
                    bytes_held_next = bytes_held_reg - CNT_W'(1);
                    if (chunk_count_reg == CC_W'(1))
                        tail_len_next = pop_len;
                    else
                        head_len_next = pop_len;
                    state_next = ST_IDLE;
                    if ((pop_len == '0) && (chunk_count_reg > CC_W'(1)))
                    begin
                        chunk_head_next  = head_inc;
                        chunk_count_next = chunk_count_reg - CC_W'(1);
                        if (chunk_count_reg > CC_W'(2))
                        begin
                            len_rd_en   = 1'b1;
                            resume_next = ST_IDLE;
                            state_next  = ST_LOAD;
                        end
                    end
                end
            end

            ST_LOAD:
            begin
                head_len_next = len_rd_data;
                state_next    = resume_reg;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        done_next = (state_reg != ST_IDLE) && (state_next == ST_IDLE);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            resume_reg      <= ST_IDLE;
            byte_head_reg   <= '0;
            byte_tail_reg   <= '0;
            chunk_head_reg  <= '0;
            chunk_tail_reg  <= '0;
            chunk_count_reg <= '0;
            bytes_held_reg  <= '0;
            dropped_reg     <= '0;
            max_bytes_reg   <= MAX_BYTES_RESET;
            done_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            oflow_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            resume_reg      <= resume_next;
            byte_head_reg   <= byte_head_next;
            byte_tail_reg   <= byte_tail_next;
            chunk_head_reg  <= chunk_head_next;
            chunk_tail_reg  <= chunk_tail_next;
            chunk_count_reg <= chunk_count_next;
            bytes_held_reg  <= bytes_held_next;
            dropped_reg     <= dropped_next;
            max_bytes_reg   <= max_bytes_next;
            done_reg        <= done_next;
            out_valid_reg   <= out_valid_next;
            oflow_reg       <= oflow_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        head_len_reg <= head_len_next;
        tail_len_reg <= tail_len_next;
        data_reg     <= data_next;
        cstart_reg   <= cstart_next;
        clen_reg     <= clen_next;
    end

    // Result beat
    assign done          = done_reg;
    assign out_valid     = out_valid_reg;
    assign out_byte      = out_valid_reg ? byte_rd_data : '0;
    assign occupancy     = OCC_W'(bytes_held_reg);
    assign full_flag     = (CMP_W'(bytes_held_reg) >= CMP_W'(max_bytes_reg));
    assign dropped_total = dropped_reg;
    assign overflow_flag = oflow_reg;

    // Checks
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) != ST_IDLE))
        else $error("result beat without a command in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("command taken but block not busy");

    a_empty_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (chunk_count_reg == '0) |-> (bytes_held_reg == '0))
        else $error("bytes held with no chunk open");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_held_reg <= CNT_W'(CAPACITY)) && (chunk_count_reg <= CC_W'(MAX_CHUNKS)))
        else $error("byte or chunk count beyond storage");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(out_valid_reg && oflow_reg))
        else $error("pull byte and push overflow in one result");

endmodule

`default_nettype wire

[sv/docbq_ram.sv]
// Generic simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. No dependencies.
`default_nettype none

module docbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write beat
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, hold data when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for drop_oldest_chunk_byte_queue_unit: directed table, then random
// chunk streams checked beat by beat against a behavioral mirror of the queue.
// Depends on docbq_pkg and the queue RTL under sv/.

module tb_top;
    import docbq_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [BYTE_W-1:0] obyte;
        logic              ovalid;
        logic [OCC_W-1:0]  occ;
        logic              full;
        logic [DROP_W-1:0] dropped;
        logic              oflow;
    } queue_status_t;

    typedef struct {
        logic                   md;
        logic [BYTE_W-1:0]      din;
        logic                   cs;
        logic [LEN_FIELD_W-1:0] len;
        bit                     typed;
        queue_status_t          status;
    } dir_row_t;

    // Block ports
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   start        = 1'b0;
    logic                   busy;
    logic                   mode         = MODE_PUSH;
    logic [BYTE_W-1:0]      data_byte    = '0;
    logic                   chunk_start  = 1'b0;
    logic [LEN_FIELD_W-1:0] chunk_length = '0;
    logic                   done;
    logic [BYTE_W-1:0]      out_byte;
    logic                   out_valid;
    logic [OCC_W-1:0]       occupancy;
    logic                   full_flag;
    logic [DROP_W-1:0]      dropped_total;
    logic                   overflow_flag;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [MAXB_W-1:0]      cfg_data     = '0;

    // Mirror of the queue state
    logic [BYTE_W-1:0]      mirror_bytes [CAPACITY];
    logic [LEN_FIELD_W-1:0] mirror_len   [MAX_CHUNKS];
    byte_ptr_t              mirror_bhead   = '0;
    byte_ptr_t              mirror_btail   = '0;
    chunk_ptr_t             mirror_chead   = '0;
    chunk_ptr_t             mirror_ctail   = '0;
    chunk_cnt_t             mirror_chunks  = '0;
    byte_cnt_t              mirror_held    = '0;
    logic [DROP_W-1:0]      mirror_dropped = '0;
    logic [MAXB_W-1:0]      mirror_limit   = MAX_BYTES_RESET;

    queue_status_t awaited_status [$];
    queue_status_t got_front;
    dir_row_t      dir_rows [$];
    int            err_count   = 0;
    int            cycle_count = 0;
    int            chunk_left  = 0;
    bit            gaps_on     = 1'b1;

    drop_oldest_chunk_byte_queue_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .data_byte     (data_byte),
        .chunk_start   (chunk_start),
        .chunk_length  (chunk_length),
        .done          (done),
        .out_byte      (out_byte),
        .out_valid     (out_valid),
        .occupancy     (occupancy),
        .full_flag     (full_flag),
        .dropped_total (dropped_total),
        .overflow_flag (overflow_flag),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // Advance the mirror by one command and return the status it reports
    function automatic queue_status_t next_queue_status(input logic md,
                                                        input logic [BYTE_W-1:0] din,
                                                        input logic cs,
                                                        input logic [LEN_FIELD_W-1:0] len);
        queue_status_t st;
        int            last;
        int            n;
        st = '0;
        if (md == MODE_PUSH) begin
            // drop whole oldest chunks until the announced chunk fits
            if (cs) begin
                while (mirror_chunks > 0 &&
                       (int'(mirror_held) + int'(len) > int'(mirror_limit) ||
                        int'(mirror_chunks) >= MAX_CHUNKS)) begin
                    n = int'(mirror_len[mirror_chead]);
                    mirror_dropped = mirror_dropped + DROP_W'(n);
                    mirror_held    = mirror_held - byte_cnt_t'(n);
                    mirror_bhead   = byte_ptr_t'((int'(mirror_bhead) + n) % CAPACITY);
                    mirror_chead   = chunk_ptr_t'((int'(mirror_chead) + 1) % MAX_CHUNKS);
                    mirror_chunks  = mirror_chunks - CC_W'(1);
                end
            end
            // open a chunk on a start, or when none is open
            if (cs || mirror_chunks == 0) begin
                mirror_len[mirror_ctail] = '0;
                mirror_ctail  = chunk_ptr_t'((int'(mirror_ctail) + 1) % MAX_CHUNKS);
                mirror_chunks = mirror_chunks + CC_W'(1);
            end
            // store the byte unless storage is full
            if (int'(mirror_held) >= CAPACITY) begin
                st.oflow = 1'b1;
            end
            else begin
                last = (int'(mirror_ctail) + MAX_CHUNKS - 1) % MAX_CHUNKS;
                mirror_bytes[mirror_btail] = din;
                mirror_btail     = byte_ptr_t'((int'(mirror_btail) + 1) % CAPACITY);
                mirror_len[last] = mirror_len[last] + LEN_FIELD_W'(1);
                mirror_held      = mirror_held + CNT_W'(1);
            end
        end
        else if (mirror_held > 0) begin
            // skip empty head chunks, keeping the last one
            while (mirror_chunks > 1 && mirror_len[mirror_chead] == 0) begin
                mirror_chead  = chunk_ptr_t'((int'(mirror_chead) + 1) % MAX_CHUNKS);
                mirror_chunks = mirror_chunks - CC_W'(1);
            end
            st.obyte  = mirror_bytes[mirror_bhead];
            st.ovalid = 1'b1;
            mirror_bhead = byte_ptr_t'((int'(mirror_bhead) + 1) % CAPACITY);
            mirror_held  = mirror_held - CNT_W'(1);
            mirror_len[mirror_chead] = mirror_len[mirror_chead] - LEN_FIELD_W'(1);
            if (mirror_len[mirror_chead] == 0 && mirror_chunks > 1) begin
                mirror_chead  = chunk_ptr_t'((int'(mirror_chead) + 1) % MAX_CHUNKS);
                mirror_chunks = mirror_chunks - CC_W'(1);
            end
        end
        st.occ     = OCC_W'(mirror_held);
        st.full    = (int'(mirror_held) >= int'(mirror_limit));
        st.dropped = mirror_dropped;
        return st;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endfunction

    // Count cycles and check each result beat against the oldest expectation
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (rst_n && done) begin
            if (awaited_status.size() == 0) begin
                $error("result beat with no command outstanding");
                err_count++;
            end
            else begin
                got_front = awaited_status.pop_front();
                check_field("out_byte",      32'(got_front.obyte),   32'(out_byte));
                check_field("out_valid",     32'(got_front.ovalid),  32'(out_valid));
                check_field("occupancy",     32'(got_front.occ),     32'(occupancy));
                check_field("full_flag",     32'(got_front.full),    32'(full_flag));
                check_field("dropped_total", got_front.dropped,      dropped_total);
                check_field("overflow_flag", 32'(got_front.oflow),   32'(overflow_flag));
            end
        end
    end

    // Present one command beat and hold it until accepted
    task automatic send_cmd(input logic md, input logic [BYTE_W-1:0] din, input logic cs,
                            input logic [LEN_FIELD_W-1:0] len, input bit typed,
                            input queue_status_t typed_st);
        queue_status_t st;
        @(negedge clk);
        start        <= 1'b1;
        mode         <= md;
        data_byte    <= din;
        chunk_start  <= cs;
        chunk_length <= len;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        st = next_queue_status(md, din, cs, len);
        awaited_status.push_back(typed ? typed_st : st);
    endtask

    // Sometimes drop start for a random idle burst when gaps are on
    task automatic idle_burst();
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 3))
                @(negedge clk);
        end
    endtask

    // Stop issuing and wait until every result is back
    task automatic quiesce();
        @(negedge clk);
        start <= 1'b0;
        while (awaited_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_limit(input logic [MAXB_W-1:0] value);
        quiesce();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mirror_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic md, input logic [BYTE_W-1:0] din, input logic cs,
                           input logic [LEN_FIELD_W-1:0] len, input bit typed,
                           input logic [BYTE_W-1:0] obyte, input logic ovalid,
                           input logic [OCC_W-1:0] occ, input logic full,
                           input logic [DROP_W-1:0] dropped, input logic oflow);
        dir_row_t row;
        row.md     = md;
        row.din    = din;
        row.cs     = cs;
        row.len    = len;
        row.typed  = typed;
        row.status = '{obyte: obyte, ovalid: ovalid, occ: occ, full: full,
                       dropped: dropped, oflow: oflow};
        dir_rows.push_back(row);
    endtask

    // One random command: mostly well-formed chunks, some pulls, some noise
    task automatic random_item(input int push_pct);
        int                     r;
        int                     body;
        logic                   md;
        logic                   cs;
        logic [BYTE_W-1:0]      din;
        logic [LEN_FIELD_W-1:0] len;
        r   = $urandom_range(0, 99);
        din = BYTE_W'($urandom_range(0, 255));
        len = LEN_FIELD_W'($urandom_range(0, 8191));
        if (r < 10) begin
            md = 1'($urandom_range(0, 1));
            cs = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 3) != 0)
                len = LEN_FIELD_W'($urandom_range(0, 4096));
        end
        else if (r < 10 + push_pct) begin
            md = MODE_PUSH;
            if (chunk_left == 0) begin
                body = $urandom_range(1, 12);
                cs   = 1'b1;
                len  = ($urandom_range(0, 3) == 0) ? LEN_FIELD_W'($urandom_range(0, 4096))
                                                   : LEN_FIELD_W'(body);
                chunk_left = body - 1;
            end
            else begin
                cs = 1'b0;
                chunk_left--;
            end
        end
        else begin
            md = MODE_PULL;
            cs = 1'($urandom_range(0, 1));
        end
        send_cmd(md, din, cs, len, 1'b0, '0);
        idle_burst();
    endtask

    task automatic run_phase(input int n_items, input int push_pct, input bit quiet);
        for (int i = 0; i < n_items; i++) begin
            if (i % 32 == 0)
                gaps_on = !quiet && ($urandom_range(0, 3) != 0);
            random_item(push_pct);
        end
    endtask

    // Give up after the cycle limit
    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        // Directed rows; typed expectations hold only from reset
        add_row(MODE_PULL, 8'hFF, 1'b1, 13'd4096, 1, 8'h00, 0, 13'd0, 0, 32'd0, 0);
        add_row(MODE_PUSH, 8'hFF, 1'b0, 13'd0,    1, 8'h00, 0, 13'd1, 0, 32'd0, 0);
        add_row(MODE_PUSH, 8'h00, 1'b1, 13'd4096, 1, 8'h00, 0, 13'd1, 0, 32'd1, 0);
        add_row(MODE_PUSH, 8'hA5, 1'b1, 13'd1,    0, '0, 0, '0, 0, '0, 0);
        add_row(MODE_PUSH, 8'h5A, 1'b1, 13'd0,    0, '0, 0, '0, 0, '0, 0);
        add_row(MODE_PULL, 8'h00, 1'b0, 13'd0,    1, 8'h00, 1, 13'd2, 0, 32'd1, 0);
        add_row(MODE_PULL, 8'h11, 1'b0, 13'd0,    0, '0, 0, '0, 0, '0, 0);
        add_row(MODE_PULL, 8'h22, 1'b1, 13'd8191, 0, '0, 0, '0, 0, '0, 0);
        add_row(MODE_PULL, 8'h33, 1'b0, 13'd0,    1, 8'h00, 0, 13'd0, 0, 32'd1, 0);
        // empty chunk left at the head, then skipped by a pull
        add_row(MODE_PUSH, 8'h3C, 1'b1, 13'd7,    0, '0, 0, '0, 0, '0, 0);
        add_row(MODE_PUSH, 8'hC3, 1'b0, 13'd8191, 0, '0, 0, '0, 0, '0, 0);
        add_row(MODE_PULL, 8'h00, 1'b0, 13'd0,    0, '0, 0, '0, 0, '0, 0);
        add_row(MODE_PULL, 8'h00, 1'b0, 13'd0,    0, '0, 0, '0, 0, '0, 0);
        // long announced length drops every held chunk
        add_row(MODE_PUSH, 8'h81, 1'b1, 13'd4095, 0, '0, 0, '0, 0, '0, 0);
        add_row(MODE_PUSH, 8'h7E, 1'b1, 13'd4096, 1, 8'h00, 0, 13'd1, 0, 32'd2, 0);
        add_row(MODE_PUSH, 8'hFF, 1'b0, 13'd0,    0, '0, 0, '0, 0, '0, 0);
        add_row(MODE_PULL, 8'h00, 1'b0, 13'd0,    0, '0, 0, '0, 0, '0, 0);

        // Hold reset, then release it
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_cmd(dir_rows[i].md, dir_rows[i].din, dir_rows[i].cs, dir_rows[i].len,
                     dir_rows[i].typed, dir_rows[i].status);
            idle_burst();
        end

        run_phase(200, 45, 1'b0);
        set_limit(13'd16);
        run_phase(200, 50, 1'b0);

        // Limit above storage: drain, then run with only storage bounding the queue
        set_limit(13'd8191);
        gaps_on = 1'b1;
        while (mirror_held > 0) begin
            send_cmd(MODE_PULL, 8'h00, 1'b0, 13'd0, 1'b0, '0);
            idle_burst();
        end
        send_cmd(MODE_PUSH, 8'hEE, 1'b0, 13'd0, 1'b0, '0);
        chunk_left = 0;
        run_phase(120, 40, 1'b0);

        set_limit(13'd0);
        run_phase(150, 50, 1'b0);
        set_limit(MAXB_W'($urandom_range(1, 8191)));
        run_phase(200, 50, 1'b0);

        // Last stretch runs without idling
        set_limit(13'd64);
        run_phase(250, 50, 1'b1);

        quiesce();
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
